// ===== hw/rtl/indexed_vector_store_assert.svh =====
// Assertion macros for the indexed vector store.
// Used by the control module; expects aclk and aresetn in scope.
`ifndef INDEXED_VECTOR_STORE_ASSERT_SVH
`define INDEXED_VECTOR_STORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define IVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define IVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ivs_pkg.sv =====
// Shared types and constants for the indexed vector store.
// No dependencies; used by ivs_cell, ivs_ctrl and indexed_vector_store.
package ivs_pkg;

    localparam int DEPTH_DEFAULT = 64;

    // Payload field widths
    localparam int KIND_W  = 4;
    localparam int POS_W   = 7;
    localparam int NCNT_W  = 7;
    localparam int WORD_W  = 32;
    localparam int ECNT_W  = 7;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 4'd0,
        KIND_WRITE  = 4'd1,
        KIND_INSERT = 4'd2,
        KIND_ERASE  = 4'd3,
        KIND_PUSH   = 4'd4,
        KIND_POP    = 4'd5,
        KIND_CLEAR  = 4'd6,
        KIND_RESIZE = 4'd7,
        KIND_ASSIGN = 4'd8
    } kind_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } state_t;

    // Command broadcast from the controller to every storage slot
    typedef struct packed {
        logic fill;      // load the request word where lo <= index < hi
        logic shift_up;  // take the left neighbor where index > lo
        logic shift_dn;  // take the right neighbor where index >= lo
        logic rd_load;   // copy the stored word into the read chain
        logic rd_shift;  // move the read chain one slot toward slot 0
    } slot_cmd_t;

endpackage

// ===== hw/rtl/indexed_vector_store.sv =====
// Top level of the indexed vector store: a row of storage slots and a controller.
// Depends on ivs_pkg, ivs_cell and ivs_ctrl.
//
// Usage:
//   Requests arrive on the s_ stream; each transfer is one request (read, write,
//   insert, erase, push, pop, clear, resize, assign). Every request produces
//   exactly one result transfer on the m_ stream: read word, element count and
//   status.
//   Every request except a successful read is done in the accept cycle: all
//   slots load, shift up or shift down together, so the result is registered
//   into the output register, or parked while that is occupied, and a new
//   request is taken each cycle while no result is parked.
//   A successful read moves the addressed word toward slot 0 through a chain of
//   read stages, one slot per cycle; no new request is taken until its result
//   is produced.
//   The output register lets one request be accepted while a result waits; if
//   the receiver keeps stalling, the next result is parked and s_tready drops
//   until the output frees.
//   Reset (aresetn low, synchronous) empties the list and the output; stored
//   words are not cleared and are never visible until written.
module indexed_vector_store #(
    parameter int DEPTH = ivs_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // kind[3:0], position[10:4], new_count[17:11], word[49:18], zero pad
    input  logic [ivs_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_word[31:0], element_count[38:32], status[40:39], zero pad
    output logic [ivs_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int RES_W = ivs_pkg::WORD_W + ivs_pkg::ECNT_W + ivs_pkg::STAT_W;

    logic [ivs_pkg::KIND_W-1:0] kind;
    logic [ivs_pkg::POS_W-1:0]  position;
    logic [ivs_pkg::NCNT_W-1:0] new_count;
    logic [ivs_pkg::WORD_W-1:0] word;
    logic [ivs_pkg::WORD_W-1:0] read_word;
    logic [ivs_pkg::ECNT_W-1:0] element_count;
    logic [ivs_pkg::STAT_W-1:0] status;

    ivs_pkg::slot_cmd_t         cmd;
    logic [CW-1:0]              lo, hi;
    logic [ivs_pkg::WORD_W-1:0] data_word [DEPTH];
    logic [ivs_pkg::WORD_W-1:0] rd_word   [DEPTH];

    // Unpack the request fields
    assign kind      = s_tdata[3:0];
    assign position  = s_tdata[10:4];
    assign new_count = s_tdata[17:11];
    assign word      = s_tdata[49:18];

    // Pack the result fields
    assign m_tdata = {{(ivs_pkg::M_DATA_W - RES_W){1'b0}}, status, element_count, read_word};

    ivs_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .kind          (kind),
        .position      (position),
        .new_count     (new_count),
        .head_rd       (rd_word[0]),
        .cmd           (cmd),
        .lo            (lo),
        .hi            (hi),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .read_word     (read_word),
        .element_count (element_count),
        .status        (status)
    );

    // Row of slots; each sees its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        logic [ivs_pkg::WORD_W-1:0] left_word;
        logic [ivs_pkg::WORD_W-1:0] right_word;
        logic [ivs_pkg::WORD_W-1:0] right_rd;

        if (i == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = data_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_word = '0;
            assign right_rd   = '0;
        end else begin : g_mid_r
            assign right_word = data_word[i+1];
            assign right_rd   = rd_word[i+1];
        end

        ivs_cell #(
            .DEPTH(DEPTH),
            .INDEX(i)
        ) u_slot (
            .aclk       (aclk),
            .cmd        (cmd),
            .lo         (lo),
            .hi         (hi),
            .fill_word  (word),
            .left_word  (left_word),
            .right_word (right_word),
            .right_rd   (right_rd),
            .data_word  (data_word[i]),
            .rd_word    (rd_word[i])
        );
    end

endmodule

// ===== hw/rtl/ivs_cell.sv =====
// One storage slot of the indexed vector store: a word plus a read-chain stage.
// Depends on ivs_pkg; instantiated in a row by indexed_vector_store.
module ivs_cell #(
    parameter int DEPTH = ivs_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                          aclk,
    input  ivs_pkg::slot_cmd_t            cmd,
    input  logic [$clog2(DEPTH+1)-1:0]    lo,
    input  logic [$clog2(DEPTH+1)-1:0]    hi,
    input  logic [ivs_pkg::WORD_W-1:0]    fill_word,
    input  logic [ivs_pkg::WORD_W-1:0]    left_word,
    input  logic [ivs_pkg::WORD_W-1:0]    right_word,
    input  logic [ivs_pkg::WORD_W-1:0]    right_rd,
    output logic [ivs_pkg::WORD_W-1:0]    data_word,
    output logic [ivs_pkg::WORD_W-1:0]    rd_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [ivs_pkg::WORD_W-1:0] data_reg, data_next;
    logic [ivs_pkg::WORD_W-1:0] rd_reg, rd_next;

    // Pick the new stored word: fill beats shift, otherwise hold
    always_comb begin
        data_next = data_reg;
        if (cmd.fill && (IDX >= lo) && (IDX < hi)) begin
            data_next = fill_word;
        end else if (cmd.shift_up && (IDX > lo)) begin
            data_next = left_word;
        end else if (cmd.shift_dn && (IDX >= lo)) begin
            data_next = right_word;
        end
    end

    // Load or advance the read chain
    always_comb begin
        rd_next = rd_reg;
        if (cmd.rd_load) begin
            rd_next = data_reg;
        end else if (cmd.rd_shift) begin
            rd_next = right_rd;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data_word = data_reg;
    assign rd_word   = rd_reg;

endmodule

// ===== hw/rtl/ivs_ctrl.sv =====
// Request decoder, element count, sequencer and result register of the store.
// Depends on ivs_pkg and indexed_vector_store_assert.svh.
`include "indexed_vector_store_assert.svh"

module ivs_ctrl #(
    parameter int DEPTH = ivs_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ivs_pkg::KIND_W-1:0]    kind,
    input  logic [ivs_pkg::POS_W-1:0]     position,
    input  logic [ivs_pkg::NCNT_W-1:0]    new_count,
    input  logic [ivs_pkg::WORD_W-1:0]    head_rd,
    output ivs_pkg::slot_cmd_t            cmd,
    output logic [$clog2(DEPTH+1)-1:0]    lo,
    output logic [$clog2(DEPTH+1)-1:0]    hi,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ivs_pkg::WORD_W-1:0]    read_word,
    output logic [ivs_pkg::ECNT_W-1:0]    element_count,
    output logic [ivs_pkg::STAT_W-1:0]    status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = (CW > ivs_pkg::POS_W) ? CW : ivs_pkg::POS_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    ivs_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   rd_cnt_reg, rd_cnt_next;

    logic                        m_valid_reg, m_valid_next;
    logic [ivs_pkg::WORD_W-1:0]  out_word_reg;
    logic [ivs_pkg::ECNT_W-1:0]  out_cnt_reg;
    ivs_pkg::status_t            out_st_reg;
    logic [ivs_pkg::WORD_W-1:0]  hold_word_reg;
    logic [ivs_pkg::ECNT_W-1:0]  hold_cnt_reg;
    ivs_pkg::status_t            hold_st_reg;

    logic                        acc;
    logic                        out_free;
    logic                        load_out;
    logic                        load_hold;
    logic [ivs_pkg::WORD_W-1:0]  res_word;
    logic [ivs_pkg::ECNT_W-1:0]  res_cnt;
    ivs_pkg::status_t            res_st;
    logic                        res_ready;
    logic [XW-1:0]               pos_x, n_x, cnt_x;

    assign pos_x    = XW'(position);
    assign n_x      = XW'(new_count);
    assign cnt_x    = XW'(cnt_reg);
    assign s_tready = (state_reg == ivs_pkg::ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Decode the request, drive the slots, and sequence reads
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd         = '0;
        lo          = '0;
        hi          = '0;
        res_word    = '0;
        res_cnt     = '0;
        res_st      = ivs_pkg::STAT_OK;
        res_ready   = 1'b0;
        case (state_reg)
            ivs_pkg::ST_IDLE: begin
                if (acc) begin
                    res_ready = 1'b1;
                    case (kind)
                        ivs_pkg::KIND_READ: begin
                            if (pos_x < cnt_x) begin
                                cmd.rd_load = 1'b1;
                                rd_cnt_next = IW'(position);
                                res_ready   = 1'b0;
                                state_next  = ivs_pkg::ST_READ;
                            end else begin
                                res_st = ivs_pkg::STAT_RANGE;
                            end
                        end
                        ivs_pkg::KIND_WRITE: begin
                            if (pos_x < cnt_x) begin
                                cmd.fill = 1'b1;
                                lo       = CW'(position);
                                hi       = CW'(position) + 1'b1;
                            end else begin
                                res_st = ivs_pkg::STAT_RANGE;
                            end
                        end
                        ivs_pkg::KIND_INSERT: begin
                            if (pos_x > cnt_x) begin
                                res_st = ivs_pkg::STAT_RANGE;
                            end else if (cnt_x >= DEPTH_X) begin
                                res_st = ivs_pkg::STAT_FULL;
                            end else begin
                                cmd.fill     = 1'b1;
                                cmd.shift_up = 1'b1;
                                lo           = CW'(position);
                                hi           = CW'(position) + 1'b1;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        ivs_pkg::KIND_ERASE: begin
                            if (pos_x < cnt_x) begin
                                cmd.shift_dn = 1'b1;
                                lo           = CW'(position);
                                cnt_next     = cnt_reg - 1'b1;
                            end else begin
                                res_st = ivs_pkg::STAT_RANGE;
                            end
                        end
                        ivs_pkg::KIND_PUSH: begin
                            if (cnt_x >= DEPTH_X) begin
                                res_st = ivs_pkg::STAT_FULL;
                            end else begin
                                cmd.fill = 1'b1;
                                lo       = cnt_reg;
                                hi       = cnt_reg + 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        ivs_pkg::KIND_POP: begin
                            if (cnt_reg == '0) begin
                                res_st = ivs_pkg::STAT_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        ivs_pkg::KIND_CLEAR: begin
                            cnt_next = '0;
                        end
                        ivs_pkg::KIND_RESIZE: begin
                            if (n_x > DEPTH_X) begin
                                res_st = ivs_pkg::STAT_FULL;
                            end else begin
                                // Only slots from the old end up to the new end take the fill
                                cmd.fill = 1'b1;
                                lo       = cnt_reg;
                                hi       = CW'(new_count);
                                cnt_next = CW'(new_count);
                            end
                        end
                        ivs_pkg::KIND_ASSIGN: begin
                            if (n_x > DEPTH_X) begin
                                res_st = ivs_pkg::STAT_FULL;
                            end else begin
                                cmd.fill = 1'b1;
                                hi       = CW'(new_count);
                                cnt_next = CW'(new_count);
                            end
                        end
                        default: begin
                        end
                    endcase
                    res_cnt = ivs_pkg::ECNT_W'(cnt_next);
                end
            end
            ivs_pkg::ST_READ: begin
                if (rd_cnt_reg == '0) begin
                    res_ready = 1'b1;
                    res_word  = head_rd;
                    res_cnt   = ivs_pkg::ECNT_W'(cnt_reg);
                    state_next = ivs_pkg::ST_IDLE;
                end else begin
                    cmd.rd_shift = 1'b1;
                    rd_cnt_next  = rd_cnt_reg - 1'b1;
                end
            end
            ivs_pkg::ST_WAIT: begin
                res_word = hold_word_reg;
                res_cnt  = hold_cnt_reg;
                res_st   = hold_st_reg;
                if (out_free) begin
                    res_ready  = 1'b1;
                    state_next = ivs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ivs_pkg::ST_IDLE;
            end
        endcase
        // Park a finished result when the output register is still occupied
        load_out  = res_ready && out_free;
        load_hold = res_ready && !out_free;
        if (load_hold) begin
            state_next = ivs_pkg::ST_WAIT;
        end
        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ivs_pkg::ST_IDLE;
            cnt_reg     <= '0;
            rd_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_word_reg <= res_word;
            out_cnt_reg  <= res_cnt;
            out_st_reg   <= res_st;
        end
        if (load_hold) begin
            hold_word_reg <= res_word;
            hold_cnt_reg  <= res_cnt;
            hold_st_reg   <= res_st;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign read_word     = out_word_reg;
    assign element_count = out_cnt_reg;
    assign status        = out_st_reg;

    `IVS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(DEPTH), "element count beyond capacity")
    `IVS_ASSERT_NEXT(a_push_grows, acc && (kind == ivs_pkg::KIND_PUSH) && (cnt_x < DEPTH_X), cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow the list")
    `IVS_ASSERT_NEXT(a_read_keeps_cnt, state_reg == ivs_pkg::ST_READ, $stable(cnt_reg), "count changed during a read")
    `IVS_ASSERT_NOW(a_wait_has_out, state_reg == ivs_pkg::ST_WAIT, m_valid_reg, "parked result without a pending output")

endmodule
